// ----- hdl/esc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and codes for the elevator SCAN scheduler: the input and
// result words, the command word that is queued between front and back,
// and the operation, call kind and direction codes.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Default number of floors served by the car.
    localparam int NUM_FLOORS_DEF = 8;

    // Width of a floor number on the ports.
    localparam int FLOOR_W = 4;

    // Number of command words held between front and back.
    localparam int CMD_FIFO_DEPTH = 2;

    // Operation codes.
    localparam logic OP_CALL = 1'b0;
    localparam logic OP_PASS = 1'b1;

    // Call kind codes.
    typedef logic [1:0] call_kind_t;
    localparam call_kind_t KIND_CAR       = 2'd0;
    localparam call_kind_t KIND_HALL_UP   = 2'd1;
    localparam call_kind_t KIND_HALL_DOWN = 2'd2;

    // Travel direction codes.
    typedef logic [1:0] dir_t;
    localparam dir_t DIR_IDLE = 2'd0;
    localparam dir_t DIR_UP   = 2'd1;
    localparam dir_t DIR_DOWN = 2'd2;

    // Input word.
    typedef struct packed {
        logic               op;
        logic [FLOOR_W-1:0] floor;
        call_kind_t         call_kind;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [FLOOR_W-1:0] stop_floor;
        logic               is_stop;
        dir_t               direction;
        logic               last;
    } out_word_t;

    // Command word passed from the front to the back.
    typedef struct packed {
        logic               is_pass;
        call_kind_t         kind;
        logic [FLOOR_W-1:0] floor;
    } cmd_t;

endpackage : esc_pkg
`default_nettype wire

// ----- hdl/elevator_scan_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_scan_scheduler
// SCAN scheduler for one elevator car: latches calls and runs sweeps.
// ----------------------------------------------------------------------------
// Input words enter a two-entry command queue and are taken whenever it has
// room, even while results wait on the output. The scheduling engine drains
// the queue one command at a time: a call is latched into the call vectors,
// and a pass chooses a direction if the car is idle, walks floor by floor
// from the car floor to the end of the shaft, and then writes the final
// status word, stalling while a result waits for m_ready. The floor-by-floor
// walk of the engine sets the pass time; a pass with no calls pending goes
// straight to the status word. Calls with floor 0, a floor above NUM_FLOORS
// or call kind 3 are accepted and dropped.
// ----------------------------------------------------------------------------
module elevator_scan_scheduler #(
    parameter int NUM_FLOORS = esc_pkg::NUM_FLOORS_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire esc_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output esc_pkg::out_word_t      m_data
);
    import esc_pkg::*;

    logic  fifo_full;
    logic  fifo_empty;
    logic  push;
    logic  pop;
    cmd_t  push_cmd;
    cmd_t  head_cmd;

    // Input classification.
    esc_front #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Command queue.
    esc_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    // Scheduling engine.
    esc_back #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_cmd   (head_cmd),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule : elevator_scan_scheduler
`default_nettype wire

// ----- hdl/esc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esc_front
// Input side of the scheduler. Takes input words while the command queue
// has room, drops call requests with an out-of-range floor or an unknown
// kind, and turns the rest into command words for the back.
// ----------------------------------------------------------------------------
module esc_front #(
    parameter int NUM_FLOORS = esc_pkg::NUM_FLOORS_DEF
) (
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire esc_pkg::in_word_t  s_data,
    input  wire                     fifo_full,
    output logic                    push,
    output esc_pkg::cmd_t           push_cmd
);
    import esc_pkg::*;

    logic floor_ok;
    logic kind_ok;
    logic keep;

    // The queue accepts a word whenever it has a free entry.
    assign s_ready = !fifo_full;

    // Classify the word: a pass always goes on, a call only when it is valid.
    assign floor_ok = (s_data.floor != '0) && (int'(s_data.floor) <= NUM_FLOORS);
    assign kind_ok  = (s_data.call_kind == KIND_CAR) ||
                      (s_data.call_kind == KIND_HALL_UP) ||
                      (s_data.call_kind == KIND_HALL_DOWN);
    assign keep     = (s_data.op == OP_PASS) || (floor_ok && kind_ok);

    assign push = s_valid && s_ready && keep;

    // Build the command word.
    always_comb begin
        push_cmd.is_pass = (s_data.op == OP_PASS);
        push_cmd.kind    = s_data.call_kind;
        push_cmd.floor   = s_data.floor;
    end

endmodule : esc_front
`default_nettype wire

// ----- hdl/esc_cmd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esc_cmd_fifo
// Short command queue between the front and the back, so that each side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module esc_cmd_fifo (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  wire esc_pkg::cmd_t  push_cmd,
    input  wire                 pop,
    output esc_pkg::cmd_t       head_cmd,
    output logic                empty,
    output logic                full
);
    import esc_pkg::*;

    localparam int PW = $clog2(CMD_FIFO_DEPTH);

    cmd_t          mem_reg [CMD_FIFO_DEPTH];
    logic [PW:0]   wr_ptr_reg;
    logic [PW:0]   rd_ptr_reg;

    // Full when the pointers differ only in the wrap bit.
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]) &&
                   (wr_ptr_reg[PW] != rd_ptr_reg[PW]);

    assign head_cmd = mem_reg[rd_ptr_reg[PW-1:0]];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg[PW-1:0]] <= push_cmd;
        end
    end

    // Pointer update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule : esc_cmd_fifo
`default_nettype wire

// ----- hdl/esc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esc_back
// Scheduling engine. Holds the call vectors, car floor and travel direction,
// latches calls from the queue and runs a sweep for each pass command, one
// floor per cycle unless a stop awaits m_ready, via a result output register.
// ----------------------------------------------------------------------------
module esc_back #(
    parameter int NUM_FLOORS = esc_pkg::NUM_FLOORS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire esc_pkg::cmd_t  head_cmd,
    input  wire                 fifo_empty,
    output logic                pop,
    output logic                m_valid,
    input  wire                 m_ready,
    output esc_pkg::out_word_t  m_data
);
    import esc_pkg::*;

    localparam int FLW = $clog2(NUM_FLOORS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STATUS
    } state_t;

    state_t                  state_reg, state_next;
    logic [NUM_FLOORS-1:0]   car_reg, car_next;
    logic [NUM_FLOORS-1:0]   hup_reg, hup_next;
    logic [NUM_FLOORS-1:0]   hdn_reg, hdn_next;
    logic [FLW-1:0]          cur_reg, cur_next;
    logic [FLW-1:0]          scan_reg, scan_next;
    dir_t                    dir_reg, dir_next;
    logic                    out_valid_reg, out_valid_next;
    out_word_t               out_data_reg, out_data_next;

    logic [NUM_FLOORS-1:0]   all_calls;
    logic [NUM_FLOORS-1:0]   above;
    logic [NUM_FLOORS-1:0]   below;
    logic [NUM_FLOORS-1:0]   scan_sel;
    logic [NUM_FLOORS-1:0]   req_sel;
    logic                    load_ok;
    logic                    stop_here;
    logic                    at_end;
    dir_t                    new_dir;

    assign all_calls = car_reg | hup_reg | hdn_reg;
    assign load_ok   = !out_valid_reg || m_ready;

    // Floor masks relative to the car floor, and one-hot floor selects.
    always_comb begin
        for (int i = 0; i < NUM_FLOORS; i++) begin
            above[i]    = (i + 1) > int'(cur_reg);
            below[i]    = (i + 1) < int'(cur_reg);
            scan_sel[i] = (i + 1) == int'(scan_reg);
            req_sel[i]  = (i + 1) == int'(head_cmd.floor);
        end
    end

    // Stop test at the scanned floor and end-of-shaft test.
    always_comb begin
        if (dir_reg == DIR_UP) begin
            stop_here = |((car_reg | hup_reg) & scan_sel);
            at_end    = (scan_reg == FLW'(NUM_FLOORS));
        end else begin
            stop_here = |((car_reg | hdn_reg) & scan_sel);
            at_end    = (scan_reg == FLW'(1));
        end
    end

    // Direction after a sweep: reverse if calls remain the other way.
    always_comb begin
        case (dir_reg)
            DIR_UP: begin
                new_dir = ((hdn_reg != '0) || ((all_calls & below) != '0)) ?
                          DIR_DOWN : DIR_IDLE;
            end
            DIR_DOWN: begin
                new_dir = ((hup_reg != '0) || ((all_calls & above) != '0)) ?
                          DIR_UP : DIR_IDLE;
            end
            default: begin
                new_dir = DIR_IDLE;
            end
        endcase
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next     = state_reg;
        car_next       = car_reg;
        hup_next       = hup_reg;
        hdn_next       = hdn_reg;
        cur_next       = cur_reg;
        scan_next      = scan_reg;
        dir_next       = dir_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!fifo_empty) begin
                    pop = 1'b1;
                    if (!head_cmd.is_pass) begin
                        case (head_cmd.kind)
                            KIND_CAR:       car_next = car_reg | req_sel;
                            KIND_HALL_UP:   hup_next = hup_reg | req_sel;
                            KIND_HALL_DOWN: hdn_next = hdn_reg | req_sel;
                            default:        car_next = car_reg;
                        endcase
                    end else if (all_calls == '0) begin
                        state_next = ST_STATUS;
                    end else begin
                        if (dir_reg != DIR_UP && dir_reg != DIR_DOWN) begin
                            if ((all_calls & above) != '0) begin
                                dir_next = DIR_UP;
                            end else if ((all_calls & below) != '0) begin
                                dir_next = DIR_DOWN;
                            end else begin
                                dir_next = DIR_UP;
                            end
                        end
                        scan_next  = cur_reg;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (!stop_here || load_ok) begin
                    if (stop_here) begin
                        cur_next = scan_reg;
                        car_next = car_reg & ~scan_sel;
                        if (dir_reg == DIR_UP) begin
                            hup_next = hup_reg & ~scan_sel;
                        end else begin
                            hdn_next = hdn_reg & ~scan_sel;
                        end
                        out_valid_next           = 1'b1;
                        out_data_next.stop_floor = FLOOR_W'(scan_reg);
                        out_data_next.is_stop    = 1'b1;
                        out_data_next.direction  = dir_reg;
                        out_data_next.last       = 1'b0;
                    end
                    if (at_end) begin
                        state_next = ST_STATUS;
                    end else if (dir_reg == DIR_UP) begin
                        scan_next = scan_reg + FLW'(1);
                    end else begin
                        scan_next = scan_reg - FLW'(1);
                    end
                end
            end

            ST_STATUS: begin
                if (load_ok) begin
                    dir_next                 = new_dir;
                    out_valid_next           = 1'b1;
                    out_data_next.stop_floor = FLOOR_W'(cur_reg);
                    out_data_next.is_stop    = 1'b0;
                    out_data_next.direction  = new_dir;
                    out_data_next.last       = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, call vectors and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            car_reg       <= '0;
            hup_reg       <= '0;
            hdn_reg       <= '0;
            cur_reg       <= FLW'(1);
            dir_reg       <= DIR_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            car_reg       <= car_next;
            hup_reg       <= hup_next;
            hdn_reg       <= hdn_next;
            cur_reg       <= cur_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
        scan_reg     <= scan_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule : esc_back
`default_nettype wire

// ----- hdl/esc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks for the elevator SCAN scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker #(
    parameter int NUM_FLOORS = esc_pkg::NUM_FLOORS_DEF
) (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire esc_pkg::in_word_t   s_data,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire esc_pkg::out_word_t  m_data
);
    import esc_pkg::*;

    // No result word comes out right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // A waiting input word holds until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Stops are never last, and the status word always is.
    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_stop != m_data.last))
        else $error("last flag does not match status word");

    // A stop is served while moving up or down, at a floor of the shaft.
    a_stop_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_stop |->
            (m_data.direction == DIR_UP || m_data.direction == DIR_DOWN) &&
            m_data.stop_floor != '0 && int'(m_data.stop_floor) <= NUM_FLOORS)
        else $error("stop word with bad direction or floor");

endmodule : esc_checker

bind elevator_scan_scheduler esc_checker #(
    .NUM_FLOORS (NUM_FLOORS)
) u_esc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the elevator SCAN scheduler. Call and pass words go
// in through a valid/ready channel. Each accepted word is run through a
// behavioral copy of the scheduler, and the stop and status words it predicts
// are queued. The result channel is then compared field by field, in order.
// A short table of directed words comes first. It is followed by a long
// receiver hold-off that backs the block up, and then by random words under
// several idling mixes on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    import esc_pkg::*;

    localparam int         NFL         = NUM_FLOORS_DEF;
    localparam int         RUN_LIMIT   = 200000;
    localparam int         DRAIN_WAIT  = 40;
    localparam int         HOLD_CYCLES = 200;
    localparam int         PHASE_WORDS = 16;
    localparam int         PRESS_WORDS = 12;
    localparam call_kind_t KIND_BAD    = 2'd3;
    localparam out_word_t  NO_WORD     = '0;

    // One row of the directed table. A count of -1 means the predictor
    // supplies the expected words.
    typedef struct packed {
        in_word_t  word;
        int        n_typed;
        out_word_t typed_a;
        out_word_t typed_b;
    } plan_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // Scheduler state mirrored by the predictor.
    logic [NFL-1:0] car_pend  = '0;
    logic [NFL-1:0] up_pend   = '0;
    logic [NFL-1:0] down_pend = '0;
    logic [3:0]     car_at    = 4'd1;
    dir_t           heading   = DIR_IDLE;

    // Words produced by the most recent prediction.
    out_word_t sweep_out [NFL+1];
    int        sweep_n;

    out_word_t awaited_stops [$];
    plan_row_t plan [0:24];
    int        plan_n = 0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int src_pct_tab  [4] = '{0, 64, 0, 27};
    int sink_pct_tab [4] = '{0, 0, 64, 27};

    int cycle_cnt  = 0;
    int mismatches = 0;
    int n_items    = 0;
    int n_passes   = 0;
    int n_results  = 0;

    elevator_scan_scheduler u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock with an 8-unit period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic out_word_t result_word(input int fl, input logic stop,
                                              input dir_t d, input logic lst);
        out_word_t r;
        r.stop_floor = 4'(fl);
        r.is_stop    = stop;
        r.direction  = d;
        r.last       = lst;
        return r;
    endfunction

    function automatic logic [NFL-1:0] floors_above(input logic [3:0] cf);
        logic [NFL-1:0] m;
        m = '0;
        for (int f = 1; f <= NFL; f++) begin
            if (f > cf) m[f-1] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [NFL-1:0] floors_below(input logic [3:0] cf);
        logic [NFL-1:0] m;
        m = '0;
        for (int f = 1; f <= NFL; f++) begin
            if (f < cf) m[f-1] = 1'b1;
        end
        return m;
    endfunction

    // Applies one input word to the mirrored state and fills sweep_out with
    // the stop words and the closing status word that it causes.
    function automatic void predict_dispatch(input in_word_t w);
        logic [NFL-1:0] waiting;
        sweep_n = 0;
        if (w.op == OP_CALL) begin
            // Calls outside the shaft or of an unknown kind are dropped.
            if (w.floor >= 1 && w.floor <= NFL) begin
                case (w.call_kind)
                    KIND_CAR:       car_pend[w.floor-1]  = 1'b1;
                    KIND_HALL_UP:   up_pend[w.floor-1]   = 1'b1;
                    KIND_HALL_DOWN: down_pend[w.floor-1] = 1'b1;
                    default: ;
                endcase
            end
        end else begin
            waiting = car_pend | up_pend | down_pend;
            if (waiting == '0) begin
                heading = DIR_IDLE;
            end else begin
                // An idle car prefers calls above, then below; a call only
                // at its own floor sends it up.
                if (heading != DIR_UP && heading != DIR_DOWN) begin
                    if ((waiting & floors_above(car_at)) != '0) heading = DIR_UP;
                    else if ((waiting & floors_below(car_at)) != '0) heading = DIR_DOWN;
                    else heading = DIR_UP;
                end
                if (heading == DIR_UP) begin
                    for (int f = car_at; f <= NFL; f++) begin
                        if (car_pend[f-1] || up_pend[f-1]) begin
                            car_at        = 4'(f);
                            car_pend[f-1] = 1'b0;
                            up_pend[f-1]  = 1'b0;
                            sweep_out[sweep_n] = result_word(f, 1'b1, DIR_UP, 1'b0);
                            sweep_n++;
                        end
                    end
                    waiting = car_pend | up_pend | down_pend;
                    if (down_pend != '0 || (waiting & floors_below(car_at)) != '0)
                        heading = DIR_DOWN;
                    else
                        heading = DIR_IDLE;
                end else begin
                    for (int f = car_at; f >= 1; f--) begin
                        if (car_pend[f-1] || down_pend[f-1]) begin
                            car_at         = 4'(f);
                            car_pend[f-1]  = 1'b0;
                            down_pend[f-1] = 1'b0;
                            sweep_out[sweep_n] = result_word(f, 1'b1, DIR_DOWN, 1'b0);
                            sweep_n++;
                        end
                    end
                    waiting = car_pend | up_pend | down_pend;
                    if (up_pend != '0 || (waiting & floors_above(car_at)) != '0)
                        heading = DIR_UP;
                    else
                        heading = DIR_IDLE;
                end
            end
            sweep_out[sweep_n] = result_word(car_at, 1'b0, heading, 1'b1);
            sweep_n++;
        end
    endfunction

    // Mostly well-formed calls and passes, with some out-of-range noise.
    function automatic in_word_t rand_word();
        in_word_t w;
        int       r;
        r           = $urandom_range(99);
        w.op        = OP_CALL;
        w.floor     = 4'($urandom_range(NFL, 1));
        w.call_kind = call_kind_t'($urandom_range(2));
        if (r < 28) begin
            w.op = OP_PASS;
        end else if (r >= 92) begin
            w.floor     = 4'($urandom_range(15));
            w.call_kind = call_kind_t'($urandom_range(3));
        end
        return w;
    endfunction

    task automatic add_row(input logic op, input int fl, input call_kind_t kind,
                           input int n, input out_word_t a, input out_word_t b);
        plan[plan_n].word.op        = op;
        plan[plan_n].word.floor     = 4'(fl);
        plan[plan_n].word.call_kind = kind;
        plan[plan_n].n_typed        = n;
        plan[plan_n].typed_a        = a;
        plan[plan_n].typed_b        = b;
        plan_n++;
    endtask

    // Offers one word, starting at a falling edge, and records its expected
    // results once it is taken. Returns at the following falling edge.
    task automatic push_word(input in_word_t w, input int n_typed,
                             input out_word_t typed_a, input out_word_t typed_b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = w;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_dispatch(w);
        n_items++;
        if (w.op == OP_PASS) n_passes++;
        if (n_typed < 0) begin
            for (int k = 0; k < sweep_n; k++) awaited_stops.push_back(sweep_out[k]);
        end else begin
            if (n_typed > 0) awaited_stops.push_back(typed_a);
            if (n_typed > 1) awaited_stops.push_back(typed_b);
        end
        @(negedge aclk);
    endtask

    task automatic wait_all_served();
        while (awaited_stops.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_asked != hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = hold_taken + 1;
        end
        if (hold_left > 0) begin
            m_ready   = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare every accepted result word with the oldest expected word.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_stops.size() == 0) begin
                $error("result word %h arrived with nothing awaited", m_data);
                mismatches++;
            end else begin
                want = awaited_stops.pop_front();
                n_results++;
                if (m_data.stop_floor !== want.stop_floor) begin
                    $error("stop_floor: expected %0d, got %0d",
                           want.stop_floor, m_data.stop_floor);
                    mismatches++;
                end
                if (m_data.is_stop !== want.is_stop) begin
                    $error("is_stop: expected %0d, got %0d", want.is_stop, m_data.is_stop);
                    mismatches++;
                end
                if (m_data.direction !== want.direction) begin
                    $error("direction: expected %0d, got %0d",
                           want.direction, m_data.direction);
                    mismatches++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_data.last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_cnt < RUN_LIMIT) @(posedge aclk);
        $error("run did not finish within %0d cycles", RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        in_word_t w;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // Directed table. Rows with typed words hold what can be read
        // straight off the scheduler rules; the rest use the predictor.
        add_row(OP_PASS, 1, KIND_CAR, 1, result_word(1, 1'b0, DIR_IDLE, 1'b1), NO_WORD);
        add_row(OP_CALL, 0, KIND_CAR, 0, NO_WORD, NO_WORD);
        add_row(OP_CALL, 15, KIND_HALL_DOWN, 0, NO_WORD, NO_WORD);
        add_row(OP_CALL, 9, KIND_HALL_UP, 0, NO_WORD, NO_WORD);
        add_row(OP_CALL, 5, KIND_BAD, 0, NO_WORD, NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, 1, result_word(1, 1'b0, DIR_IDLE, 1'b1), NO_WORD);
        add_row(OP_CALL, 8, KIND_CAR, 0, NO_WORD, NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, 2, result_word(8, 1'b1, DIR_UP, 1'b0),
                result_word(8, 1'b0, DIR_IDLE, 1'b1));
        // Idle car whose only call is a hall-down call at its own floor.
        add_row(OP_CALL, 8, KIND_HALL_DOWN, 0, NO_WORD, NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, 1, result_word(8, 1'b0, DIR_DOWN, 1'b1), NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, 2, result_word(8, 1'b1, DIR_DOWN, 1'b0),
                result_word(8, 1'b0, DIR_IDLE, 1'b1));
        add_row(OP_CALL, 1, KIND_CAR, -1, NO_WORD, NO_WORD);
        add_row(OP_CALL, 1, KIND_HALL_UP, -1, NO_WORD, NO_WORD);
        add_row(OP_CALL, 3, KIND_HALL_DOWN, -1, NO_WORD, NO_WORD);
        add_row(OP_CALL, 5, KIND_HALL_UP, -1, NO_WORD, NO_WORD);
        add_row(OP_CALL, 6, KIND_CAR, -1, NO_WORD, NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, -1, NO_WORD, NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, -1, NO_WORD, NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, -1, NO_WORD, NO_WORD);
        add_row(OP_CALL, 8, KIND_HALL_UP, -1, NO_WORD, NO_WORD);
        add_row(OP_CALL, 1, KIND_HALL_DOWN, -1, NO_WORD, NO_WORD);
        add_row(OP_CALL, 2, KIND_CAR, -1, NO_WORD, NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, -1, NO_WORD, NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, -1, NO_WORD, NO_WORD);
        add_row(OP_PASS, 0, KIND_CAR, -1, NO_WORD, NO_WORD);

        for (int k = 0; k < plan_n; k++) begin
            push_word(plan[k].word, plan[k].n_typed, plan[k].typed_a, plan[k].typed_b);
        end
        s_valid = 1'b0;
        wait_all_served();

        // Back-pressure: the receiver holds off while words keep coming,
        // so the command queue fills and the input stalls.
        hold_asked = hold_asked + 1;
        for (int k = 0; k < PRESS_WORDS; k++) begin
            w = rand_word();
            if (k % 3 == 2) w.op = OP_PASS;
            push_word(w, -1, NO_WORD, NO_WORD);
        end
        s_valid = 1'b0;
        wait_all_served();

        // Random words under each idling mix, draining between mixes.
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = src_pct_tab[ph];
            sink_stall_pct = sink_pct_tab[ph];
            for (int k = 0; k < PHASE_WORDS; k++) begin
                push_word(rand_word(), -1, NO_WORD, NO_WORD);
            end
            s_valid = 1'b0;
            wait_all_served();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (awaited_stops.size() != 0) begin
            $error("%0d expected result words never arrived", awaited_stops.size());
            mismatches++;
        end

        $display("Sent %0d words (%0d scheduling passes), checked %0d result words.",
                 n_items, n_passes, n_results);
        $display("Idling mixes on both channels and a %0d-cycle output hold-off, %0d cycles.",
                 HOLD_CYCLES, cycle_cnt);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
